// ===== rtl/core/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Monochrome framebuffer raster engine: shared package
// Operation and draw-mode codes, controller states, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam logic [2:0] OP_PIXEL  = 3'd0;
  localparam logic [2:0] OP_VBLOCK = 3'd1;
  localparam logic [2:0] OP_HLINE  = 3'd2;
  localparam logic [2:0] OP_VLINE  = 3'd3;
  localparam logic [2:0] OP_FILL   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;
  localparam logic [2:0] OP_NONE   = 3'd7;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_XOR   = 2'd2;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FINISH
  } mfb_state_t;

  typedef struct packed {
    logic load;
    logic walk_step;
    logic wr_commit;
    logic sweep_init;
    logic sweep_step;
    logic out_load;
  } mfb_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic walk_none;
    logic walk_last;
    logic sweep_last;
  } mfb_status_t;

  // Ones in bit positions lo..hi of a word, lo <= hi.
  function automatic logic [31:0] span_mask(input logic [4:0] lo, input logic [4:0] hi);
    span_mask = (ALL_ONES >> (5'd31 - hi)) & (ALL_ONES << lo);
  endfunction

endpackage

// ===== rtl/core/mfb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module mfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Monochrome framebuffer raster engine: controller
// Sequences the clearing sweep, the read-modify-write walk over the words of
// one command and the hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module mfb_ctrl
  import mfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  mfb_status_t status,
  output mfb_cmd_t    cmd
);

  mfb_state_t state_r, state_nxt;
  logic       sweep_op_r, sweep_op_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    sweep_op_nxt = sweep_op_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (status.sweep_last) begin
          state_nxt = sweep_op_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          sweep_op_nxt = status.is_clear;
          if (status.is_clear) begin
            state_nxt = ST_SWEEP;
          end else if (status.walk_none) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = status.walk_last ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.sweep_init = status.is_clear;
        end
      end
      ST_READ: begin
      end
      ST_WRITE: begin
        cmd.wr_commit = 1'b1;
        cmd.walk_step = !status.walk_last;
      end
      ST_FINISH: begin
        cmd.out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_op_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_op_r  <= sweep_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // A clear-all command must go straight into the sweep.
  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && status.is_clear) |=> (state_r == ST_SWEEP))
    else $error("clear command did not start the sweep");

  // A new result never overwrites one the receiver is still holding off.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

endmodule

// ===== rtl/core/mfb_datapath.sv =====
// ----------------------------------------------------------------------------
// Monochrome framebuffer raster engine: datapath
// Holds the command, walks the column and word-row counters, builds the bit
// mask for each word, and performs the read-modify-write on the frame store.
// ----------------------------------------------------------------------------
module mfb_datapath
  import mfb_pkg::*;
#(
  parameter int COLUMNS   = 128,
  parameter int WORD_ROWS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_x_start,
  input  logic [6:0]  in_x_end,
  input  logic [5:0]  in_y_start,
  input  logic [5:0]  in_y_end,
  input  logic [31:0] in_pattern,
  input  logic [1:0]  in_draw_mode,
  input  mfb_cmd_t    cmd,
  output mfb_status_t status,
  output logic [31:0] out_read_data
);

  localparam int DEPTH = COLUMNS * WORD_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [2:0]    op_r;
  logic [6:0]    x0_r, x1_r, cur_x_r;
  logic [5:0]    y0_r, y1_r;
  logic [1:0]    wl_r, cur_w_r;
  logic [31:0]   pat_r;
  logic [1:0]    mode_r;
  logic [31:0]   result_r;
  logic [31:0]   out_data_r;
  logic [AW-1:0] sw_r, sw_nxt;

  // Decode of the incoming command.
  logic       rect_x, rect_y;
  logic [6:0] x1_in;
  logic [5:0] y1_in;
  logic [1:0] w0_in, wl_in;

  always_comb begin
    rect_x = (in_operation == OP_HLINE) || (in_operation == OP_FILL);
    rect_y = (in_operation == OP_VLINE) || (in_operation == OP_FILL);
    x1_in  = rect_x ? in_x_end : in_x_start;
    y1_in  = rect_y ? in_y_end : in_y_start;
    w0_in  = {1'b0, in_y_start[5]};
    // A vblock that is not word aligned spills into the next word row.
    if (rect_x || rect_y) begin
      wl_in = {1'b0, y1_in[5]};
    end else if ((in_operation == OP_VBLOCK) && (in_y_start[4:0] != 5'd0)) begin
      wl_in = w0_in + 2'd1;
    end else begin
      wl_in = w0_in;
    end
  end

  assign status.is_clear   = (in_operation == OP_CLEAR);
  assign status.walk_none  = (in_operation == OP_NONE) ||
                             (rect_x && (in_x_end < in_x_start)) ||
                             (rect_y && (in_y_end < in_y_start));
  assign status.walk_last  = (cur_x_r == x1_r) && (cur_w_r == wl_r);
  assign status.sweep_last = (sw_r == AW'(DEPTH - 1));

  // Word address and range check of the current walk position.
  logic [31:0] addr_full;
  logic [AW-1:0] addr;
  logic        in_range;

  assign addr_full = 32'(cur_x_r) * 32'(WORD_ROWS) + 32'(cur_w_r);
  assign addr      = addr_full[AW-1:0];
  assign in_range  = (32'(cur_x_r) < 32'(COLUMNS)) && (32'(cur_w_r) < 32'(WORD_ROWS));

  // Mask for the current word.
  logic [4:0]  lo, hi;
  logic [63:0] vb_wide;
  logic [31:0] mask;
  logic [31:0] rdata;
  logic [31:0] new_word;

  always_comb begin
    lo      = (cur_w_r == {1'b0, y0_r[5]}) ? y0_r[4:0] : 5'd0;
    hi      = (cur_w_r == {1'b0, y1_r[5]}) ? y1_r[4:0] : 5'd31;
    vb_wide = {32'd0, pat_r} << y0_r[4:0];
    if (op_r == OP_VBLOCK) begin
      mask = (cur_w_r == {1'b0, y0_r[5]}) ? vb_wide[31:0] : vb_wide[63:32];
    end else begin
      mask = span_mask(lo, hi);
    end
    case (mode_r)
      MODE_XOR:   new_word = rdata ^ mask;
      MODE_CLEAR: new_word = rdata & ~mask;
      default:    new_word = rdata | mask;
    endcase
  end

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;

  assign ram_we    = cmd.sweep_step ||
                     (cmd.wr_commit && in_range && (op_r != OP_READ));
  assign ram_waddr = cmd.sweep_step ? sw_r : addr;
  assign ram_wdata = cmd.sweep_step ? 32'd0 : new_word;

  mfb_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  // Command registers and walk counters.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      x0_r     <= in_x_start;
      x1_r     <= x1_in;
      y0_r     <= in_y_start;
      y1_r     <= y1_in;
      wl_r     <= wl_in;
      pat_r    <= in_pattern;
      mode_r   <= in_draw_mode;
      cur_x_r  <= in_x_start;
      cur_w_r  <= w0_in;
      result_r <= 32'd0;
    end else begin
      if (cmd.walk_step) begin
        if (cur_x_r != x1_r) begin
          cur_x_r <= cur_x_r + 7'd1;
        end else begin
          cur_x_r <= x0_r;
          cur_w_r <= cur_w_r + 2'd1;
        end
      end
      if (cmd.wr_commit && in_range && (op_r == OP_READ)) begin
        result_r <= rdata;
      end
    end
    if (cmd.out_load) begin
      out_data_r <= result_r;
    end
  end

  always_comb begin
    if (cmd.sweep_init) begin
      sw_nxt = '0;
    end else if (cmd.sweep_step) begin
      sw_nxt = sw_r + AW'(1);
    end else begin
      sw_nxt = sw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= '0;
    end else begin
      sw_r <= sw_nxt;
    end
  end

  assign out_read_data = out_data_r;

  // The walk never steps past the far corner of the command.
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_commit |-> ((cur_x_r <= x1_r) && (cur_w_r <= wl_r)))
    else $error("walk left the command rectangle");

  // Every command starts with a zero result.
  a_result_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (result_r == 32'd0))
    else $error("result not cleared at command load");

endmodule

// ===== rtl/core/mono_framebuffer_raster_engine.sv =====
// ----------------------------------------------------------------------------
// Monochrome framebuffer raster engine
// Draws pixels, vertical patterns, lines and filled rectangles into a 1-bit
// framebuffer held as 32-bit vertical words, and reads words back.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_ channel: a beat is taken when in_valid is high
//   and in_stall is low. Every command yields exactly one beat on the out_
//   channel, carrying the framebuffer word for a read and zero otherwise.
//   The store is one word-wide RAM with a registered read port, so each word
//   a command touches passes through a fetch state that reads it and a write
//   state that writes the modified word back, or for a read captures it.
//   A reversed range or the unused operation code skips the walk and goes
//   straight to handing over its result. A clear-all command sweeps the
//   whole store, one word per cycle, before its result is offered.
//   After reset the same sweep runs and in_stall stays high until it
//   finishes. The result is held in an output register, so a new command is
//   accepted while the receiver stalls; the engine only waits when it has a
//   further result to hand over and the register is full.
// ----------------------------------------------------------------------------
module mono_framebuffer_raster_engine
  import mfb_pkg::*;
#(
  parameter int COLUMNS   = 128,
  parameter int WORD_ROWS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_x_start,
  input  logic [6:0]  in_x_end,
  input  logic [5:0]  in_y_start,
  input  logic [5:0]  in_y_end,
  input  logic [31:0] in_pattern,
  input  logic [1:0]  in_draw_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data
);

  // The controller decides what happens in each cycle; the datapath holds the
  // command, the walk position, the mask logic and the frame store itself.
  mfb_cmd_t    cmd;
  mfb_status_t status;

  mfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The walk covers columns in the inner loop and word rows in the outer
  // loop; writes that land outside the store are suppressed but still walked.
  mfb_datapath #(
    .COLUMNS   (COLUMNS),
    .WORD_ROWS (WORD_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_operation  (in_operation),
    .in_x_start    (in_x_start),
    .in_x_end      (in_x_end),
    .in_y_start    (in_y_start),
    .in_y_end      (in_y_end),
    .in_pattern    (in_pattern),
    .in_draw_mode  (in_draw_mode),
    .cmd           (cmd),
    .status        (status),
    .out_read_data (out_read_data)
  );

endmodule
